@@ hdl/bsc_pkg.sv @@
`default_nettype none
package bsc_pkg;

  localparam int unsigned RAW_W  = 24;
  localparam int unsigned TEMP_W = 16;
  localparam int unsigned PRES_W = 18;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_DIV0    = 2'd1,
    STAT_NO_TEMP = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_e;

  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_PRES  = 1'b1;

  localparam logic signed [63:0] B6_OFFSET  = 64'sd4000;
  localparam logic signed [63:0] P_COEF_SQ  = 64'sd3038;
  localparam logic signed [63:0] P_COEF_LIN = -64'sd7357;
  localparam logic signed [63:0] P_OFFSET   = 64'sd3791;
  localparam logic signed [63:0] X3_BIAS    = 64'sd32768;
  localparam logic [16:0]        B7_SCALE   = 17'd50000;
  localparam logic signed [63:0] PRES_MAX   = 64'sd262143;
  localparam logic signed [63:0] TEMP_MAX   = 64'sd32767;
  localparam logic signed [63:0] TEMP_MIN   = -64'sd32768;

endpackage
`default_nettype wire

@@ hdl/bsc_if.sv @@
`default_nettype none
interface bsc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [bsc_pkg::RAW_W-1:0]      raw_reading;

  modport source (output valid, op, raw_reading, input ready);
  modport sink   (input valid, op, raw_reading, output ready);
endinterface

interface bsc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [bsc_pkg::TEMP_W-1:0] temperature_tenths;
  logic [bsc_pkg::PRES_W-1:0]        pressure_pa;
  logic [1:0]                        status;

  modport source (output valid, kind, temperature_tenths, pressure_pa, status, input ready);
  modport sink   (input valid, kind, temperature_tenths, pressure_pa, status, output ready);
endinterface
`default_nettype wire

@@ hdl/barometric_sensor_compensation_top.sv @@
`default_nettype none
// Barometric compensation engine for temperature items (op 0) and pressure items (op 1).
// Each item is worked by one shared shift-add multiplier that retires one multiplier bit
// per cycle (16 to 29 bits per product, one product per temperature item, ten per pressure
// item) and one restoring divider that retires one quotient bit per cycle (32 quotient
// bits), each driven from a control step in ST_RUN. Items flagged with a status code finish
// earlier. One item is in work at a time. The input is ready whenever the engine is idle,
// from the cycle after the result is loaded, so a new item is taken only once the last one
// is through. A finished result waits in the output register while the next item is
// accepted. The user must see that calibration words are written over the APB port only
// while idle; the block itself does not enforce this.
module barometric_sensor_compensation_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  bsc_in_if.sink                              in_ch,
  bsc_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bsc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [bsc_pkg::DATA_W-1:0]     pwdata,
  output logic      [bsc_pkg::DATA_W-1:0]     prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_MUL, ST_DIV, ST_EMIT} state_e;
  typedef enum logic [3:0] {
    S_T0, S_T1, S_T2,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11
  } step_e;

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;
  state_e      st_q;
  step_e       step_q;
  logic        op_q;
  logic [23:0] raw_q;
  logic signed [31:0] b5_q;
  logic        seen_q;
  logic signed [63:0] t_q, b3_q;
  logic signed [28:0] b6_q;
  logic signed [44:0] sq_q;
  logic [16:0] b4_q;
  logic signed [31:0] pq_q;
  logic        neg_q, shq_q;
  logic signed [63:0] ma_q, mb_q, mp_q;
  logic [4:0]  mn_q;
  logic [31:0] dq_q, dr_q, dd_q;
  logic [5:0]  dn_q;
  logic        ov_q, okind_q;
  logic signed [15:0] otemp_q;
  logic [17:0] opres_q;
  logic [1:0]  ostat_q;
  logic        rkind_q;
  logic signed [15:0] rtemp_q;
  logic [17:0] rpres_q;
  bsc_pkg::status_e rstat_q;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0] ac4, ac5, ac6;
  assign ac1 = signed'(ac12_q[31:16]);
  assign ac2 = signed'(ac12_q[15:0]);
  assign ac3 = signed'(ac34_q[31:16]);
  assign ac4 = ac34_q[15:0];
  assign ac5 = ac56_q[31:16];
  assign ac6 = ac56_q[15:0];
  assign b1  = signed'(b12_q[31:16]);
  assign b2  = signed'(b12_q[15:0]);
  assign mc  = signed'(mcmd_q[31:16]);
  assign md  = signed'(mcmd_q[15:0]);

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  always_comb begin
    case (paddr[4:2])
      bsc_pkg::REG_AC1_AC2: prdata = ac12_q;
      bsc_pkg::REG_AC3_AC4: prdata = ac34_q;
      bsc_pkg::REG_AC5_AC6: prdata = ac56_q;
      bsc_pkg::REG_B1_B2:   prdata = b12_q;
      bsc_pkg::REG_MC_MD:   prdata = mcmd_q;
      bsc_pkg::REG_OSS:     prdata = {30'd0, oss_q};
      default:              prdata = '0;
    endcase
  end

  // multiplier step: subtract on the sign bit of the multiplier
  logic signed [63:0] mul_nx;
  assign mul_nx = (mn_q == 5'd1) ? (mp_q - ma_q) : (mp_q + ma_q);

  // divider step
  logic [32:0] div_r, div_s;
  logic        div_ge;
  assign div_r  = {dr_q, dq_q[31]};
  assign div_s  = div_r - {1'b0, dd_q};
  assign div_ge = div_r >= {1'b0, dd_q};

  // temperature datapath
  logic signed [63:0] x1t, dent, numt, qt, b5n, tt, tsat;
  assign x1t  = mp_q >>> 15;
  assign dent = x1t + 64'(md);
  assign numt = 64'(mc) <<< 11;
  assign qt   = neg_q ? -$signed({32'd0, dq_q}) : $signed({32'd0, dq_q});
  assign b5n  = t_q + qt;
  assign tt   = (b5n + 64'sd8) >>> 4;
  assign tsat = (tt > bsc_pkg::TEMP_MAX) ? bsc_pkg::TEMP_MAX :
                (tt < bsc_pkg::TEMP_MIN) ? bsc_pkg::TEMP_MIN : tt;

  // pressure datapath
  logic signed [63:0] x3a, b3n, x3b, up64, x4, pfin, psat;
  logic [31:0] x3w, b7, qp;
  assign x3a  = t_q + (mp_q >>> 11);
  assign b3n  = ((((64'(ac1) <<< 2) + x3a) <<< oss_q) + 64'sd2) >>> 2;
  assign x3b  = (t_q + (mp_q >>> 16) + 64'sd2) >>> 2;
  assign x3w  = 32'(x3b + bsc_pkg::X3_BIAS);
  assign up64 = $signed({40'd0, raw_q >> (4'd8 - {2'd0, oss_q})});
  assign b7   = mp_q[31:0];
  assign qp   = shq_q ? {dq_q[30:0], 1'b0} : dq_q;
  assign x4   = 64'(pq_q) + ((t_q + (mp_q >>> 16) + bsc_pkg::P_OFFSET) >>> 4);
  assign psat = (x4 < 64'sd0) ? 64'sd0 : (x4 > bsc_pkg::PRES_MAX) ? bsc_pkg::PRES_MAX : x4;
  assign pfin = psat;

  assign in_ch.ready        = (st_q == ST_IDLE);
  assign out_ch.valid       = ov_q;
  assign out_ch.kind        = okind_q;
  assign out_ch.temperature_tenths = otemp_q;
  assign out_ch.pressure_pa = opres_q;
  assign out_ch.status      = ostat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0; ac34_q <= '0; ac56_q <= '0; b12_q <= '0; mcmd_q <= '0; oss_q <= '0;
      st_q <= ST_IDLE; step_q <= S_T0; op_q <= 1'b0; raw_q <= '0;
      b5_q <= '0; seen_q <= 1'b0; t_q <= '0; b3_q <= '0; b6_q <= '0; sq_q <= '0;
      b4_q <= '0; pq_q <= '0; neg_q <= 1'b0; shq_q <= 1'b0;
      ma_q <= '0; mb_q <= '0; mp_q <= '0; mn_q <= '0;
      dq_q <= '0; dr_q <= '0; dd_q <= '0; dn_q <= '0;
      ov_q <= 1'b0; okind_q <= 1'b0; otemp_q <= '0; opres_q <= '0; ostat_q <= '0;
      rkind_q <= 1'b0; rtemp_q <= '0; rpres_q <= '0; rstat_q <= bsc_pkg::STAT_OK;
    end else begin
      if (cfg_we) begin
        case (paddr[4:2])
          bsc_pkg::REG_AC1_AC2: ac12_q <= pwdata;
          bsc_pkg::REG_AC3_AC4: ac34_q <= pwdata;
          bsc_pkg::REG_AC5_AC6: ac56_q <= pwdata;
          bsc_pkg::REG_B1_B2:   b12_q  <= pwdata;
          bsc_pkg::REG_MC_MD:   mcmd_q <= pwdata;
          bsc_pkg::REG_OSS:     oss_q  <= pwdata[1:0];
          default: ;
        endcase
      end
      // load a finished result, else drop the one taken by the sink
      if (st_q == ST_EMIT && (!ov_q || out_ch.ready)) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ch.ready) begin
        ov_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_ch.valid) begin
            op_q    <= in_ch.op;
            raw_q   <= in_ch.raw_reading;
            rkind_q <= in_ch.op;
            rtemp_q <= '0;
            rpres_q <= '0;
            rstat_q <= bsc_pkg::STAT_OK;
            step_q  <= (in_ch.op == bsc_pkg::OP_PRES) ? S_P0 : S_T0;
            st_q    <= ST_RUN;
          end
        end
        ST_MUL: begin
          mp_q <= mb_q[0] ? mul_nx : mp_q;
          ma_q <= ma_q <<< 1;
          mb_q <= mb_q >>> 1;
          mn_q <= mn_q - 5'd1;
          if (mn_q == 5'd1) st_q <= ST_RUN;
        end
        ST_DIV: begin
          dr_q <= div_ge ? div_s[31:0] : div_r[31:0];
          dq_q <= {dq_q[30:0], div_ge};
          dn_q <= dn_q - 6'd1;
          if (dn_q == 6'd1) st_q <= ST_RUN;
        end
        ST_EMIT: begin
          if (!ov_q || out_ch.ready) begin
            okind_q <= rkind_q;
            otemp_q <= rtemp_q;
            opres_q <= rpres_q;
            ostat_q <= rstat_q;
            st_q    <= ST_IDLE;
          end
        end
        ST_RUN: begin
          case (step_q)
            S_T0: begin
              mp_q <= '0; ma_q <= 64'($signed({1'b0, raw_q[15:0]}) - $signed({1'b0, ac6}));
              mb_q <= $signed({48'd0, ac5}); mn_q <= 5'd17;
              step_q <= S_T1; st_q <= ST_MUL;
            end
            S_T1: begin
              t_q <= x1t;
              if (dent == 64'sd0) begin
                rstat_q <= bsc_pkg::STAT_DIV0;
                st_q <= ST_EMIT;
              end else begin
                neg_q <= numt[63] ^ dent[63];
                dq_q  <= numt[63] ? 32'(-numt) : numt[31:0];
                dd_q  <= dent[63] ? 32'(-dent) : dent[31:0];
                dr_q  <= '0; dn_q <= 6'd32;
                step_q <= S_T2; st_q <= ST_DIV;
              end
            end
            S_T2: begin
              b5_q    <= 32'(b5n);
              seen_q  <= 1'b1;
              rtemp_q <= 16'(tsat);
              st_q    <= ST_EMIT;
            end
            S_P0: begin
              if (!seen_q) begin
                rstat_q <= bsc_pkg::STAT_NO_TEMP;
                st_q <= ST_EMIT;
              end else begin
                b6_q <= 29'(64'(b5_q) - bsc_pkg::B6_OFFSET);
                mp_q <= '0; ma_q <= 64'(b5_q) - bsc_pkg::B6_OFFSET;
                mb_q <= 64'(b5_q) - bsc_pkg::B6_OFFSET; mn_q <= 5'd29;
                step_q <= S_P1; st_q <= ST_MUL;
              end
            end
            S_P1: begin
              sq_q <= 45'(mp_q >>> 12);
              mp_q <= '0; ma_q <= mp_q >>> 12; mb_q <= 64'(b2); mn_q <= 5'd16;
              step_q <= S_P2; st_q <= ST_MUL;
            end
            S_P2: begin
              t_q <= mp_q >>> 11;
              mp_q <= '0; ma_q <= 64'(b6_q); mb_q <= 64'(ac2); mn_q <= 5'd16;
              step_q <= S_P3; st_q <= ST_MUL;
            end
            S_P3: begin
              b3_q <= b3n;
              mp_q <= '0; ma_q <= 64'(b6_q); mb_q <= 64'(ac3); mn_q <= 5'd16;
              step_q <= S_P4; st_q <= ST_MUL;
            end
            S_P4: begin
              t_q <= mp_q >>> 13;
              mp_q <= '0; ma_q <= 64'(sq_q); mb_q <= 64'(b1); mn_q <= 5'd16;
              step_q <= S_P5; st_q <= ST_MUL;
            end
            S_P5: begin
              mp_q <= '0; ma_q <= $signed({32'd0, x3w});
              mb_q <= $signed({48'd0, ac4}); mn_q <= 5'd17;
              step_q <= S_P6; st_q <= ST_MUL;
            end
            S_P6: begin
              b4_q <= mp_q[31:15];
              mp_q <= '0; ma_q <= $signed({32'd0, 32'(up64 - b3_q)});
              mb_q <= $signed({47'd0, bsc_pkg::B7_SCALE >> oss_q}); mn_q <= 5'd17;
              step_q <= S_P7; st_q <= ST_MUL;
            end
            S_P7: begin
              if (b4_q == 17'd0) begin
                rstat_q <= bsc_pkg::STAT_DIV0;
                st_q <= ST_EMIT;
              end else begin
                shq_q <= b7[31];
                dq_q  <= b7[31] ? b7 : {b7[30:0], 1'b0};
                dd_q  <= {15'd0, b4_q};
                dr_q  <= '0; dn_q <= 6'd32;
                step_q <= S_P8; st_q <= ST_DIV;
              end
            end
            S_P8: begin
              pq_q <= signed'(qp);
              mp_q <= '0; ma_q <= 64'(signed'(qp) >>> 8);
              mb_q <= 64'(signed'(qp) >>> 8); mn_q <= 5'd24;
              step_q <= S_P9; st_q <= ST_MUL;
            end
            S_P9: begin
              mp_q <= '0; ma_q <= mp_q; mb_q <= bsc_pkg::P_COEF_SQ; mn_q <= 5'd16;
              step_q <= S_P10; st_q <= ST_MUL;
            end
            S_P10: begin
              t_q <= mp_q >>> 16;
              mp_q <= '0; ma_q <= 64'(pq_q); mb_q <= bsc_pkg::P_COEF_LIN; mn_q <= 5'd16;
              step_q <= S_P11; st_q <= ST_MUL;
            end
            S_P11: begin
              rpres_q <= 18'(pfin);
              st_q    <= ST_EMIT;
            end
            default: st_q <= ST_IDLE;
          endcase
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/bsc_checker.sv @@
`default_nettype none
module bsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        kind_i,
  input wire logic [15:0] temperature_i,
  input wire logic [17:0] pressure_i,
  input wire logic [1:0]  status_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pressure_i) && $stable(status_i))
    else $error("result dropped or changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

  a_temp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !kind_i |-> pressure_i == 18'd0 &&
      status_i != 2'(bsc_pkg::STAT_NO_TEMP))
    else $error("temperature result carries pressure");

  a_pres_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i |-> temperature_i == 16'd0)
    else $error("pressure result carries temperature");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != 2'(bsc_pkg::STAT_OK) |-> pressure_i == 18'd0 &&
      temperature_i == 16'd0)
    else $error("failed item carries a value");

endmodule

bind barometric_sensor_compensation_top bsc_checker u_bsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .kind_i        (out_ch.kind),
  .temperature_i (out_ch.temperature_tenths),
  .pressure_i    (out_ch.pressure_pa),
  .status_i      (out_ch.status)
);
`default_nettype wire

@@ tb/tb_bsc_if.sv @@
`timescale 1ns / 1ps

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic                              kind;
    logic signed [bsc_pkg::TEMP_W-1:0] temp;
    logic [bsc_pkg::PRES_W-1:0]        pres;
    bsc_pkg::status_e                  status;
  } reading_t;

  typedef struct {
    int        cfg_set;   // 0 keep, else calibration set applied before the item
    logic      op;
    logic [23:0] raw;
    bit        typed;
    reading_t  want;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [bsc_pkg::ADDR_W-1:0] paddr;
  logic [bsc_pkg::DATA_W-1:0] pwdata, prdata;

  bsc_in_if  in_ch ();
  bsc_out_if out_ch ();

  barometric_sensor_compensation_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of calibration and state
  logic [31:0]   cal_words [5];
  logic [1:0]    oss_cfg;
  longint        b5_term;
  bit            b5_valid;

  reading_t      pending_q [$];
  int            err_cnt;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_reqs;
  int            hold_seen;
  int            hold_left;
  longint        cyc_cnt;

  function automatic longint s16(logic [15:0] w);
    longint v;
    v = $signed(w);
    return v;
  endfunction

  function automatic reading_t compensate(logic op, logic [23:0] raw);
    reading_t    r;
    longint      ut, ac5, ac6, mc, md, x1, x2, x3, den, t, up;
    longint      ac1, ac2, ac3, b1, b2, b6, sq, b3, p;
    logic [31:0] ac4, x3w, diffw, b4, b7, q;
    logic [63:0] prod;
    r = '0;
    r.kind = op;
    r.status = bsc_pkg::STAT_OK;
    if (op == bsc_pkg::OP_TEMP) begin
      ut  = longint'(raw[15:0]);
      ac5 = longint'(cal_words[bsc_pkg::REG_AC5_AC6][31:16]);
      ac6 = longint'(cal_words[bsc_pkg::REG_AC5_AC6][15:0]);
      mc  = s16(cal_words[bsc_pkg::REG_MC_MD][31:16]);
      md  = s16(cal_words[bsc_pkg::REG_MC_MD][15:0]);
      x1  = ((ut - ac6) * ac5) >>> 15;
      den = x1 + md;
      if (den == 0) begin
        r.status = bsc_pkg::STAT_DIV0;
        return r;
      end
      b5_term = x1 + (mc * 2048) / den;
      b5_valid = 1'b1;
      t = (b5_term + 8) >>> 4;
      if (t > bsc_pkg::TEMP_MAX) t = bsc_pkg::TEMP_MAX;
      if (t < bsc_pkg::TEMP_MIN) t = bsc_pkg::TEMP_MIN;
      r.temp = t[15:0];
      return r;
    end
    if (!b5_valid) begin
      r.status = bsc_pkg::STAT_NO_TEMP;
      return r;
    end
    up  = longint'(raw >> (8 - oss_cfg));
    ac1 = s16(cal_words[bsc_pkg::REG_AC1_AC2][31:16]);
    ac2 = s16(cal_words[bsc_pkg::REG_AC1_AC2][15:0]);
    ac3 = s16(cal_words[bsc_pkg::REG_AC3_AC4][31:16]);
    ac4 = {16'b0, cal_words[bsc_pkg::REG_AC3_AC4][15:0]};
    b1  = s16(cal_words[bsc_pkg::REG_B1_B2][31:16]);
    b2  = s16(cal_words[bsc_pkg::REG_B1_B2][15:0]);
    b6  = b5_term - bsc_pkg::B6_OFFSET;
    sq  = (b6 * b6) >>> 12;
    x1  = (b2 * sq) >>> 11;
    x2  = (ac2 * b6) >>> 11;
    x3  = x1 + x2;
    b3  = ((ac1 * 4 + x3) * (longint'(1) << oss_cfg) + 2) >>> 2;
    x1  = (ac3 * b6) >>> 13;
    x2  = (b1 * sq) >>> 16;
    x3  = (x1 + x2 + 2) >>> 2;
    x3w = 32'(x3 + bsc_pkg::X3_BIAS);
    prod = {32'b0, ac4} * {32'b0, x3w};
    b4  = prod[31:0] >> 15;
    diffw = 32'(up - b3);
    prod = {32'b0, diffw} * 64'(bsc_pkg::B7_SCALE >> oss_cfg);
    b7  = prod[31:0];
    if (b4 == 0) begin
      r.status = bsc_pkg::STAT_DIV0;
      return r;
    end
    if (b7 < 32'h8000_0000) q = (b7 << 1) / b4;
    else q = (b7 / b4) << 1;
    p  = longint'($signed(q));
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * bsc_pkg::P_COEF_SQ) >>> 16;
    x2 = (bsc_pkg::P_COEF_LIN * p) >>> 16;
    p  = p + ((x1 + x2 + bsc_pkg::P_OFFSET) >>> 4);
    if (p < 0) p = 0;
    if (p > bsc_pkg::PRES_MAX) p = bsc_pkg::PRES_MAX;
    r.pres = p[17:0];
    return r;
  endfunction

  // receiver: random stalls, long hold-off on request, result check
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result kind=%0d temp=%0d pres=%0d status=%0d", $time,
                 out_ch.kind, out_ch.temperature_tenths, out_ch.pressure_pa, out_ch.status);
      end else begin
        reading_t e;
        e = pending_q.pop_front();
        if (out_ch.kind !== e.kind || out_ch.temperature_tenths !== e.temp ||
            out_ch.pressure_pa !== e.pres || out_ch.status !== e.status) begin
          err_cnt++;
          $display("%0t: mismatch expected kind=%0d temp=%0d pres=%0d status=%0d", $time,
                   e.kind, e.temp, e.pres, e.status);
          $display("%0t:          actual   kind=%0d temp=%0d pres=%0d status=%0d", $time,
                   out_ch.kind, out_ch.temperature_tenths, out_ch.pressure_pa,
                   out_ch.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic put_item(logic op, logic [23:0] raw, bit typed, reading_t want);
    reading_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.raw_reading <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
    got = compensate(op, raw);
    pending_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic reg_write(bsc_pkg::reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bsc_pkg::ADDR_W'(int'(idx) * 4);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (idx == bsc_pkg::REG_OSS) oss_cfg = val[1:0];
    else cal_words[idx] = val;
  endtask

  task automatic load_cal(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                          logic [31:0] w3, logic [31:0] w4, logic [1:0] oss);
    drain();
    reg_write(bsc_pkg::REG_AC1_AC2, w0);
    reg_write(bsc_pkg::REG_AC3_AC4, w1);
    reg_write(bsc_pkg::REG_AC5_AC6, w2);
    reg_write(bsc_pkg::REG_B1_B2, w3);
    reg_write(bsc_pkg::REG_MC_MD, w4);
    reg_write(bsc_pkg::REG_OSS, {30'b0, oss});
  endtask

  // typical factory words: AC1 408, AC2 -72, AC3 -14383, AC4 32741, AC5 32757,
  // AC6 23153, B1 6190, B2 4, MC -8727, MD 2868
  localparam logic [31:0] DS_W0 = {16'd408, 16'hFFB8};
  localparam logic [31:0] DS_W1 = {16'hC7D1, 16'd32741};
  localparam logic [31:0] DS_W2 = {16'd32757, 16'd23153};
  localparam logic [31:0] DS_W3 = {16'd6190, 16'd4};
  localparam logic [31:0] DS_W4 = {16'hDDE9, 16'd2868};

  function automatic reading_t flag(logic kind, bsc_pkg::status_e st);
    reading_t r;
    r = '0;
    r.kind = kind;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] w);
    return {w[31:16] + 16'($urandom_range(64)) - 16'd32,
            w[15:0] + 16'($urandom_range(64)) - 16'd32};
  endfunction

  step_row_t rows [$];

  initial begin
    step_row_t row;
    reading_t  none;
    logic      op;
    logic [23:0] raw;
    int        sent;
    int        burst;
    none = '0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = bsc_pkg::OP_TEMP;
    in_ch.raw_reading = '0;
    out_ch.ready = 1'b0;
    err_cnt = 0;
    cyc_cnt = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (cal_words[i]) cal_words[i] = '0;
    oss_cfg = '0;
    b5_term = 0;
    b5_valid = 1'b0;

    rows = '{
      '{0, bsc_pkg::OP_PRES, 24'h000000, 1, flag(bsc_pkg::OP_PRES, bsc_pkg::STAT_NO_TEMP)},
      '{0, bsc_pkg::OP_PRES, 24'hFFFFFF, 1, flag(bsc_pkg::OP_PRES, bsc_pkg::STAT_NO_TEMP)},
      '{0, bsc_pkg::OP_TEMP, 24'h000000, 1, flag(bsc_pkg::OP_TEMP, bsc_pkg::STAT_DIV0)},
      '{0, bsc_pkg::OP_TEMP, 24'hFFFFFF, 1, flag(bsc_pkg::OP_TEMP, bsc_pkg::STAT_DIV0)},
      '{0, bsc_pkg::OP_PRES, 24'h5D2300, 1, flag(bsc_pkg::OP_PRES, bsc_pkg::STAT_NO_TEMP)},
      '{1, bsc_pkg::OP_TEMP, 24'h006CFA, 0, none},
      '{0, bsc_pkg::OP_PRES, 24'h5D2300, 0, none},
      '{0, bsc_pkg::OP_PRES, 24'h000000, 0, none},
      '{0, bsc_pkg::OP_PRES, 24'hFFFFFF, 0, none},
      '{0, bsc_pkg::OP_TEMP, 24'h000000, 0, none},
      '{0, bsc_pkg::OP_PRES, 24'h800000, 0, none},
      '{0, bsc_pkg::OP_TEMP, 24'hFFFFFF, 0, none},
      '{0, bsc_pkg::OP_PRES, 24'h7FFFFF, 0, none},
      '{0, bsc_pkg::OP_TEMP, 24'hAA55AA, 0, none},
      '{2, bsc_pkg::OP_PRES, 24'h5D2300, 1, flag(bsc_pkg::OP_PRES, bsc_pkg::STAT_DIV0)},
      '{3, bsc_pkg::OP_TEMP, 24'h006CFA, 1, flag(bsc_pkg::OP_TEMP, bsc_pkg::STAT_DIV0)},
      '{0, bsc_pkg::OP_PRES, 24'h123456, 1, flag(bsc_pkg::OP_PRES, bsc_pkg::STAT_DIV0)}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      case (row.cfg_set)
        1: load_cal(DS_W0, DS_W1, DS_W2, DS_W3, DS_W4, 2'd0);
        2: begin
          drain();
          reg_write(bsc_pkg::REG_AC3_AC4, {DS_W1[31:16], 16'd0});
        end
        3: begin
          drain();
          reg_write(bsc_pkg::REG_AC5_AC6, 32'd0);
          reg_write(bsc_pkg::REG_MC_MD, {DS_W4[31:16], 16'd0});
        end
        default: ;
      endcase
      put_item(row.op, row.raw, row.typed, row.want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_cal(DS_W0, DS_W1, DS_W2, DS_W3, DS_W4, 2'd1);
        1: load_cal(jitter(DS_W0), jitter(DS_W1), jitter(DS_W2), jitter(DS_W3),
                    jitter(DS_W4), 2'd3);
        2: load_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
        3: load_cal(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 2'd3);
        4: load_cal(32'h7FFF8000, 32'h8000FFFF, 32'hFFFF0000, 32'h80007FFF,
                    32'h7FFF8001, 2'd2);
        default: load_cal(jitter(DS_W0), jitter(DS_W1), jitter(DS_W2), jitter(DS_W3),
                          jitter(DS_W4), 2'd0);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      // let the output back up while the sender keeps offering items
      if (ph == 0) hold_reqs++;
      sent = 0;
      while (sent < 72) begin
        if (ph == 2 && sent == 36) begin
          in_ch.valid <= 1'b0;
          wait (pending_q.size() == 0);
          @(posedge clk_i);
        end
        if ($urandom_range(9) < 8) begin
          // temperature first, then a few pressure readings
          raw = 24'($urandom);
          if ($urandom_range(1)) raw[15:0] = 16'($urandom_range(32000, 24000));
          put_item(bsc_pkg::OP_TEMP, raw, 0, none);
          burst = $urandom_range(4, 1);
          for (int k = 0; k < burst; k++) begin
            raw = 24'($urandom);
            if ($urandom_range(1)) raw = 24'($urandom_range(26000, 20000)) << 8;
            put_item(bsc_pkg::OP_PRES, raw, 0, none);
          end
          sent += burst + 1;
        end else begin
          op = 1'($urandom);
          put_item(op, 24'($urandom), 0, none);
          sent++;
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
